### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// next-cycle implication, active during reset too
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/tpdo_pkg.sv
// ----------------------------------------------------------------------------
// tpdo_pkg
// Types, widths and constants of the time proportioning heater output.
// ----------------------------------------------------------------------------
package tpdo_pkg;

  localparam int unsigned TS_W      = 32;  // timestamps and accumulators
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TMO_W-1:0]  STALE_RESET = 16'd30000;
  localparam logic [DUTY_W-1:0] FULL_DUTY   = 7'd100;

  // 1000*on >= 10*duty*total reduces exactly to 100*on >= duty*total
  localparam int unsigned RATIO_SCALE = 1000;
  localparam int unsigned DUTY_SCALE  = 10;
  localparam int unsigned RATIO_STEP  = RATIO_SCALE / DUTY_SCALE;

  localparam int unsigned TOT_W = TS_W + 1;
  localparam int unsigned LHS_W = TS_W + DUTY_W;
  localparam int unsigned RHS_W = TOT_W + DUTY_W;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_UPDATE = 2'd0,
    KIND_ENABLE = 2'd1,
    KIND_DUTY   = 2'd2,
    KIND_OFF    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INVERT  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_t;

  // classified operations
  typedef enum logic [2:0] {
    OP_UPDATE  = 3'd0,
    OP_ENABLE  = 3'd1,
    OP_DISABLE = 3'd2,
    OP_DUTY    = 3'd3,
    OP_OFF     = 3'd4
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [TS_W-1:0]  now_ms;
    logic [DUTY_W-1:0] duty;
  } req_t;

  typedef struct packed {
    logic             invert;
    logic [TMO_W-1:0] timeout;
  } cfg_t;

endpackage

### rtl/tpdo_ifs.sv
// ----------------------------------------------------------------------------
// tpdo channel interfaces
// Valid/ready channels for events, results and register writes.
// ----------------------------------------------------------------------------
interface tpdo_in_if;
  import tpdo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [TS_W-1:0]         now_ms;
  logic signed [VAL_W-1:0] value;
  modport source (output valid, kind, now_ms, value, input ready);
  modport sink   (input valid, kind, now_ms, value, output ready);
endinterface

interface tpdo_out_if;
  import tpdo_pkg::*;
  logic            valid;
  logic            ready;
  logic            pin_level;
  logic            pin_written;
  logic [TS_W-1:0] on_time_ms;
  logic [TS_W-1:0] off_time_ms;
  modport source (output valid, pin_level, pin_written, on_time_ms, off_time_ms,
                  input ready);
  modport sink   (input valid, pin_level, pin_written, on_time_ms, off_time_ms,
                  output ready);
endinterface

interface tpdo_cfg_if;
  import tpdo_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TMO_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/time_proportioning_duty_output.sv
// ----------------------------------------------------------------------------
// time_proportioning_duty_output: time proportioning heater pin driver
// Sequence: an update runs load, sum, multiply, product, commit; other kinds skip
// multiply and product. Commit registers the result once the output is free. The
// back end takes requests only in load; the two-entry queue takes them meanwhile.
// Reset: synchronous, clears counters, pin, enable, duty; stale timeout 30000 ms.
// ----------------------------------------------------------------------------
module time_proportioning_duty_output (
  input  logic       clk,
  input  logic       rst_n,
  tpdo_in_if.sink    in_if,
  tpdo_out_if.source out_if,
  tpdo_cfg_if.sink   cfg_if
);
  import tpdo_pkg::*;

  logic             invert_r;
  logic [TMO_W-1:0] timeout_r;
  cfg_t             cfg;
  logic             q_valid;
  logic             q_ready;
  req_t             q_req;

  // register writes are always taken
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r  <= 1'b0;
      timeout_r <= STALE_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_t'(cfg_if.index))
        CFG_INVERT:  invert_r  <= cfg_if.data[0];
        CFG_TIMEOUT: timeout_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign cfg.invert  = invert_r;
  assign cfg.timeout = timeout_r;

  tpdo_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_req   (q_req)
  );

  tpdo_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_req   (q_req),
    .out_if  (out_if)
  );

endmodule

### rtl/tpdo_front.sv
// ----------------------------------------------------------------------------
// tpdo_front
// Accepts event requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module tpdo_front (
  input  logic          clk,
  input  logic          rst_n,
  tpdo_in_if.sink       in_if,
  output logic          q_valid,
  input  logic          q_ready,
  output tpdo_pkg::req_t q_req
);
  import tpdo_pkg::*;

  req_t              cls;
  req_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;
  logic              push;
  logic              pop;

  // classify: fold enable flag into the op, clamp negative duty to zero
  always_comb begin
    cls.now_ms = in_if.now_ms;
    cls.duty   = '0;
    cls.op     = OP_UPDATE;
    unique case (kind_t'(in_if.kind))
      KIND_UPDATE: cls.op = OP_UPDATE;
      KIND_ENABLE: cls.op = (in_if.value != '0) ? OP_ENABLE : OP_DISABLE;
      KIND_DUTY: begin
        cls.op   = OP_DUTY;
        cls.duty = in_if.value[VAL_W-1] ? '0 : in_if.value[DUTY_W-1:0];
      end
      KIND_OFF:    cls.op = OP_OFF;
      default:     cls.op = OP_UPDATE;
    endcase
  end

  // queue handshake
  assign in_if.ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid     = (count_r != '0);
  assign q_req       = q_mem_r[rd_ptr_r];
  assign push        = in_if.valid && in_if.ready;
  assign pop         = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### rtl/tpdo_back.sv
// ----------------------------------------------------------------------------
// tpdo_back
// Sequencer that does the time accounting, the duty decision and the result.
// ----------------------------------------------------------------------------
module tpdo_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tpdo_pkg::cfg_t cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  tpdo_pkg::req_t q_req,
  tpdo_out_if.source     out_if
);
  import tpdo_pkg::*;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_SUM    = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_PROD   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;

  // current request
  op_t               op_r;
  logic [TS_W-1:0]   now_r;
  logic [DUTY_W-1:0] duty_in_r;
  logic [TS_W-1:0]   gap_r;
  logic              stale_r;

  // datapath
  logic [TS_W-1:0]   t_on_r;
  logic [TS_W-1:0]   t_off_r;
  logic [TOT_W-1:0]  total_r;
  logic [LHS_W-1:0]  lhs_r;
  logic [RHS_W-1:0]  rhs_r;
  logic [TS_W-1:0]   gap_now;
  logic [TOT_W-1:0]  sum_on;
  logic [TOT_W-1:0]  sum_off;
  logic [TS_W-1:0]   sat_on;
  logic [TS_W-1:0]   sat_off;

  // block state
  logic [TS_W-1:0]   on_acc_r,  on_acc_nxt;
  logic [TS_W-1:0]   off_acc_r, off_acc_nxt;
  logic [TS_W-1:0]   last_r,    last_nxt;
  logic              pin_r,     pin_nxt;
  logic              en_r,      en_nxt;
  logic [DUTY_W-1:0] duty_r,    duty_nxt;

  // result register
  logic              out_valid_r;
  logic              out_level_r;
  logic              out_written_r;
  logic [TS_W-1:0]   out_on_r;
  logic [TS_W-1:0]   out_off_r;

  logic              commit_go;
  logic              decide;
  logic              do_acct;
  logic              want;

  assign q_ready   = (state_r == S_LOAD);
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || out_if.ready);
  assign gap_now   = q_req.now_ms - last_r;

  // saturating add of the gap to the counter the pin selects
  assign sum_on  = {1'b0, on_acc_r} + {1'b0, gap_r};
  assign sum_off = {1'b0, off_acc_r} + {1'b0, gap_r};
  assign sat_on  = sum_on[TS_W]  ? '1 : sum_on[TS_W-1:0];
  assign sat_off = sum_off[TS_W] ? '1 : sum_off[TS_W-1:0];

  // on while enabled unless the on share has reached the duty
  assign decide = en_r && ((duty_r >= FULL_DUTY) ||
                           ((duty_r != '0) && (RHS_W'(lhs_r) < rhs_r)));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:   if (q_valid) state_nxt = S_SUM;
      S_SUM:    state_nxt = (op_r == OP_UPDATE) ? S_MUL : S_COMMIT;
      S_MUL:    state_nxt = S_PROD;
      S_PROD:   state_nxt = S_COMMIT;
      S_COMMIT: if (commit_go) state_nxt = S_LOAD;
      default:  state_nxt = S_LOAD;
    endcase
  end

  // next block state at commit
  always_comb begin
    on_acc_nxt  = on_acc_r;
    off_acc_nxt = off_acc_r;
    last_nxt    = last_r;
    en_nxt      = en_r;
    duty_nxt    = duty_r;
    pin_nxt     = pin_r;
    do_acct     = 1'b0;
    want        = 1'b0;
    unique case (op_r)
      OP_UPDATE: begin
        do_acct = 1'b1;
        want    = decide;
      end
      OP_OFF:    do_acct = 1'b1;
      OP_DISABLE: begin
        if (en_r) begin
          en_nxt  = 1'b0;
          do_acct = 1'b1;
        end
      end
      OP_ENABLE: begin
        if (!en_r) begin
          en_nxt      = 1'b1;
          on_acc_nxt  = '0;
          off_acc_nxt = '0;
          last_nxt    = now_r;
        end
      end
      OP_DUTY: begin
        if (duty_in_r != duty_r) begin
          duty_nxt    = duty_in_r;
          on_acc_nxt  = '0;
          off_acc_nxt = '0;
          last_nxt    = now_r;
        end
      end
      default: ;
    endcase
    // a stale gap clears both counters and adds nothing
    if (do_acct) begin
      on_acc_nxt  = stale_r ? '0 : t_on_r;
      off_acc_nxt = stale_r ? '0 : t_off_r;
      last_nxt    = now_r;
      pin_nxt     = want && en_nxt;
    end
  end

  // control and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
      on_acc_r    <= '0;
      off_acc_r   <= '0;
      last_r      <= '0;
      pin_r       <= 1'b0;
      en_r        <= 1'b0;
      duty_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit_go) begin
        out_valid_r <= 1'b1;
        on_acc_r    <= on_acc_nxt;
        off_acc_r   <= off_acc_nxt;
        last_r      <= last_nxt;
        pin_r       <= pin_nxt;
        en_r        <= en_nxt;
        duty_r      <= duty_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      op_r      <= q_req.op;
      now_r     <= q_req.now_ms;
      duty_in_r <= q_req.duty;
      gap_r     <= gap_now;
      stale_r   <= gap_now > {{(TS_W-TMO_W){1'b0}}, cfg.timeout};
    end
    if (state_r == S_SUM) begin
      t_on_r  <= pin_r ? sat_on : on_acc_r;
      t_off_r <= pin_r ? off_acc_r : sat_off;
    end
    if (state_r == S_MUL) begin
      total_r <= {1'b0, t_on_r} + {1'b0, t_off_r};
      lhs_r   <= LHS_W'(t_on_r) * LHS_W'(RATIO_STEP);
    end
    if (state_r == S_PROD) begin
      rhs_r <= RHS_W'(duty_r) * RHS_W'(total_r);
    end
    if (commit_go) begin
      out_level_r   <= pin_nxt ^ cfg.invert;
      out_written_r <= pin_nxt != pin_r;
      out_on_r      <= on_acc_nxt;
      out_off_r     <= off_acc_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.pin_level   = out_level_r;
  assign out_if.pin_written = out_written_r;
  assign out_if.on_time_ms  = out_on_r;
  assign out_if.off_time_ms = out_off_r;

endmodule

### rtl/tpdo_checker.sv
// ----------------------------------------------------------------------------
// tpdo_checker
// Port-level checks on the heater output block, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpdo_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  pin_level,
  input logic                  pin_written,
  input logic [tpdo_pkg::TS_W-1:0] on_time_ms,
  input logic [tpdo_pkg::TS_W-1:0] off_time_ms
);
  import tpdo_pkg::*;

  // no result survives reset
  `ASSERT_NEXT_ALWAYS(a_reset_no_result, clk, !rst_n, !out_valid)

  // a stalled result stays and holds its payload
  `ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pin_level) && $stable(pin_written) && $stable(on_time_ms) && $stable(off_time_ms))

  // register writes never stall
  `ASSERT_IMPL(a_cfg_open, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind time_proportioning_duty_output tpdo_checker u_tpdo_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .cfg_ready   (cfg_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .pin_level   (out_if.pin_level),
  .pin_written (out_if.pin_written),
  .on_time_ms  (out_if.on_time_ms),
  .off_time_ms (out_if.off_time_ms)
);

### tb/sv/time_proportioning_duty_output_checker.sv
// ----------------------------------------------------------------------------
// time_proportioning_duty_output_checker
// Watches the event, result and register channels of the heater output block,
// forecasts each result from its own copy of the counters, pin and settings,
// and compares every field of every result in order.
// ----------------------------------------------------------------------------
module time_proportioning_duty_output_checker (
  input  logic clk,
  input  logic rst_n,
  tpdo_in_if   in_mon,
  tpdo_out_if  out_mon,
  tpdo_cfg_if  cfg_mon,
  output int   fail_count,
  output int   results_pending
);
  import tpdo_pkg::*;

  typedef struct packed {
    logic            pin_level;
    logic            pin_written;
    logic [TS_W-1:0] on_ms;
    logic [TS_W-1:0] off_ms;
  } heat_result_t;

  // forecast copy of the block's settings and state
  logic              invert_q;
  logic [TMO_W-1:0]  timeout_q;
  logic [TS_W-1:0]   on_acc;
  logic [TS_W-1:0]   off_acc;
  logic [TS_W-1:0]   mark_ms;
  logic              heat_on;
  logic              armed;
  logic [DUTY_W-1:0] duty_q;

  heat_result_t heat_forecast_q[$];

  function automatic logic [TS_W-1:0] sat_add32(input logic [TS_W-1:0] a,
                                                input logic [TS_W-1:0] b);
    logic [TS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TS_W] ? '1 : s[TS_W-1:0];
  endfunction

  function automatic void clear_counts(input logic [TS_W-1:0] now);
    on_acc  = '0;
    off_acc = '0;
    mark_ms = now;
  endfunction

  // charge the elapsed gap to the current pin state; 1 when the pin toggles
  function automatic logic charge_gap(input logic [TS_W-1:0] now, input logic want);
    logic [TS_W-1:0] gap;
    logic            nxt;
    gap = now - mark_ms;
    if (gap > TS_W'(timeout_q)) begin
      on_acc  = '0;
      off_acc = '0;
      gap     = '0;
    end
    if (heat_on) on_acc = sat_add32(on_acc, gap);
    else off_acc = sat_add32(off_acc, gap);
    mark_ms = now;
    nxt = want & armed;
    if (nxt != heat_on) begin
      heat_on = nxt;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // duty decision: on unless 1000*on >= 10*duty*(on+off), gap charged without timeout
  function automatic logic want_heat(input logic [TS_W-1:0] now);
    logic [TS_W-1:0] gap;
    logic [TS_W-1:0] t_on;
    logic [TS_W-1:0] t_off;
    logic [63:0]     total;
    logic [63:0]     lhs;
    logic [63:0]     rhs;
    if (!armed) return 1'b0;
    if (duty_q >= FULL_DUTY) return 1'b1;
    if (duty_q == '0) return 1'b0;
    gap   = now - mark_ms;
    t_on  = on_acc;
    t_off = off_acc;
    if (heat_on) t_on = sat_add32(t_on, gap);
    else t_off = sat_add32(t_off, gap);
    total = 64'(t_on) + 64'(t_off);
    lhs   = 64'(RATIO_SCALE) * 64'(t_on);
    rhs   = 64'(DUTY_SCALE) * 64'(duty_q) * total;
    return !(lhs >= rhs);
  endfunction

  function automatic heat_result_t forecast_event(input kind_t k,
                                                  input logic [TS_W-1:0] now,
                                                  input logic signed [VAL_W-1:0] v);
    heat_result_t      r;
    logic              wr;
    logic              want;
    logic [DUTY_W-1:0] d;
    wr = 1'b0;
    case (k)
      KIND_UPDATE: wr = charge_gap(now, want_heat(now));
      KIND_ENABLE: begin
        want = (v != '0);
        if (want != armed) begin
          armed = want;
          if (want) clear_counts(now);
          else wr = charge_gap(now, 1'b0);
        end
      end
      KIND_DUTY: begin
        // negative duty clamps to zero, 100 and up stays as full on
        d = v[VAL_W-1] ? '0 : v[DUTY_W-1:0];
        if (d != duty_q) begin
          duty_q = d;
          clear_counts(now);
        end
      end
      default: wr = charge_gap(now, 1'b0);
    endcase
    r.pin_level   = heat_on ^ invert_q;
    r.pin_written = wr;
    r.on_ms       = on_acc;
    r.off_ms      = off_acc;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [TS_W-1:0] got,
                                 input logic [TS_W-1:0] want);
    $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin : watch
    heat_result_t want_r;
    if (!rst_n) begin
      invert_q  = 1'b0;
      timeout_q = STALE_RESET;
      clear_counts('0);
      heat_on   = 1'b0;
      armed     = 1'b0;
      duty_q    = '0;
      heat_forecast_q.delete();
    end else begin
      // register write
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_idx_t'(cfg_mon.index) == CFG_INVERT) invert_q = cfg_mon.data[0];
        else timeout_q = cfg_mon.data;
      end
      // result against the oldest forecast
      if (out_mon.valid && out_mon.ready) begin
        if (heat_forecast_q.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          want_r = heat_forecast_q.pop_front();
          if (out_mon.pin_level !== want_r.pin_level)
            report_mismatch("pin_level", TS_W'(out_mon.pin_level), TS_W'(want_r.pin_level));
          if (out_mon.pin_written !== want_r.pin_written)
            report_mismatch("pin_written", TS_W'(out_mon.pin_written),
                            TS_W'(want_r.pin_written));
          if (out_mon.on_time_ms !== want_r.on_ms)
            report_mismatch("on_time_ms", out_mon.on_time_ms, want_r.on_ms);
          if (out_mon.off_time_ms !== want_r.off_ms)
            report_mismatch("off_time_ms", out_mon.off_time_ms, want_r.off_ms);
        end
      end
      // accepted request
      if (in_mon.valid && in_mon.ready)
        heat_forecast_q.push_back(forecast_event(kind_t'(in_mon.kind), in_mon.now_ms,
                                                 in_mon.value));
    end
    results_pending <= heat_forecast_q.size();
  end

endmodule

### tb/sv/time_proportioning_duty_output_tb.sv
// ----------------------------------------------------------------------------
// time_proportioning_duty_output_tb
// Drives timestamped heater events and register writes into the time
// proportioning output, with random gaps and receiver stalls, and leaves the
// result checking to the checker beside the block.
// ----------------------------------------------------------------------------
module time_proportioning_duty_output_tb;
  import tpdo_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  logic clk;
  logic rst_n;

  tpdo_in_if  in_ch();
  tpdo_out_if out_ch();
  tpdo_cfg_if cfg_ch();

  int          fail_count;
  int          results_pending;
  logic        in_taken;
  logic        cfg_taken;
  int unsigned quiet_cycles = 0;

  bit              src_idle_en   = 1'b1;
  bit              sink_idle_en  = 1'b1;
  int              hold_requests = 0;
  logic [TS_W-1:0] event_ms      = '0;
  int unsigned     tmo_now       = STALE_RESET;

  time_proportioning_duty_output i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  time_proportioning_duty_output_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // handshake flags for the drivers, plus the stall watchdog
  always @(posedge clk) begin
    in_taken  <= in_ch.valid && in_ch.ready;
    cfg_taken <= cfg_ch.valid && cfg_ch.ready;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result receiver: random stalls, long hold-off on request
  initial begin : sink_side
    int hold_left;
    int hold_served;
    hold_left    = 0;
    hold_served  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (sink_idle_en) begin
        out_ch.ready = ($urandom_range(99) >= 36);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // offer one event; valid stays up after acceptance for a back-to-back request
  task automatic send_event(input kind_t k, input logic [TS_W-1:0] t,
                            input logic signed [VAL_W-1:0] v);
    while (src_idle_en && $urandom_range(99) < 36) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.kind   = k;
    in_ch.now_ms = t;
    in_ch.value  = v;
    do @(negedge clk); while (!in_taken);
  endtask

  // stop offering and let every result come out
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // both registers, block idle; spare bits of the invert write are random
  task automatic apply_settings(input logic invert, input logic [TMO_W-1:0] tmo);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = CFG_INVERT;
    cfg_ch.data  = TMO_W'({$urandom_range(32767, 0), invert});
    do @(negedge clk); while (!cfg_taken);
    cfg_ch.index = CFG_TIMEOUT;
    cfg_ch.data  = tmo;
    do @(negedge clk); while (!cfg_taken);
    cfg_ch.valid = 1'b0;
    tmo_now      = tmo;
  endtask

  // mostly updates at plausible spacing, with stale gaps, time jumps and setting changes
  task automatic random_events(input int count);
    kind_t                   k;
    logic signed [VAL_W-1:0] v;
    int unsigned             pick;
    int unsigned             span;
    for (int n = 0; n < count; n++) begin
      span = (tmo_now == 0) ? 1 : tmo_now;
      pick = $urandom_range(99);
      if (pick >= 93) event_ms = $urandom();
      else if (pick >= 78) event_ms += tmo_now + $urandom_range(3000, 1);
      else if (pick >= 8) event_ms += $urandom_range(span, 1);
      pick = $urandom_range(99);
      v    = VAL_W'($urandom());
      if (pick < 80) begin
        k = KIND_UPDATE;
      end else if (pick < 87) begin
        k = KIND_ENABLE;
        if ($urandom_range(99) < 30) v = '0;
      end else if (pick < 94) begin
        k = KIND_DUTY;
        if ($urandom_range(99) < 75) v = VAL_W'($urandom_range(99, 1));
      end else begin
        k = KIND_OFF;
      end
      send_event(k, event_ms, v);
    end
  endtask

  initial begin : stimulus
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_UPDATE;
    in_ch.now_ms = '0;
    in_ch.value  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_INVERT;
    cfg_ch.data  = '0;
    rst_n        = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset settings, invert off, timeout 30000
    send_event(KIND_UPDATE, 32'd0, 8'sd0);        // disabled update stays off
    send_event(KIND_ENABLE, 32'd5, 8'sd1);        // enable clears counters
    send_event(KIND_UPDATE, 32'd5, 8'sd0);        // zero duty
    send_event(KIND_DUTY, 32'd10, 8'sd50);
    send_event(KIND_UPDATE, 32'd10, 8'sd0);       // zero total stays off
    send_event(KIND_UPDATE, 32'd110, 8'sd0);
    send_event(KIND_UPDATE, 32'd210, 8'sd0);      // on share exactly at duty
    send_event(KIND_DUTY, 32'd300, 8'sd127);      // top of full-on range
    send_event(KIND_UPDATE, 32'd400, 8'sd0);
    send_event(KIND_DUTY, 32'd500, 8'sh80);       // most negative clamps to zero
    send_event(KIND_UPDATE, 32'd600, 8'sd0);
    send_event(KIND_DUTY, 32'd700, 8'sd100);
    send_event(KIND_DUTY, 32'd710, 8'sd100);      // unchanged duty
    send_event(KIND_UPDATE, 32'd720, 8'sd0);
    send_event(KIND_ENABLE, 32'd730, 8'sh80);     // already enabled
    send_event(KIND_UPDATE, 32'd30720, 8'sd0);    // gap equal to timeout is kept
    send_event(KIND_UPDATE, 32'd60721, 8'sd0);    // gap past timeout clears
    send_event(KIND_DUTY, 32'd60800, 8'sd1);
    send_event(KIND_UPDATE, 32'd60800, 8'sd0);
    send_event(KIND_UPDATE, 32'd61800, 8'sd0);
    send_event(KIND_UPDATE, 32'd62800, 8'sd0);
    // huge wrapping gap saturates the decision copy
    send_event(KIND_UPDATE, 32'd62800 + 32'hFFFF_FF00, 8'sd0);
    send_event(KIND_ENABLE, 32'd62554, 8'sd0);    // disable while on
    send_event(KIND_OFF, 32'd62600, 8'sd0);       // force off while disabled
    send_event(KIND_ENABLE, 32'd62700, 8'sh80);   // negative value enables
    send_event(KIND_DUTY, 32'd62800, 8'shFF);
    send_event(KIND_UPDATE, 32'hFFFF_FFFF, 8'sd0);
    event_ms = 32'hFFFF_FFFF;
    drain_results();

    // random phases across settings; long receiver hold-off fills the block
    apply_settings(1'b1, 16'hFFFF);
    hold_requests++;
    random_events(400);
    drain_results();

    apply_settings(1'b0, 16'h0000);
    random_events(250);
    drain_results();

    apply_settings(1'b1, TMO_W'($urandom_range(3000, 50)));
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    random_events(450);
    drain_results();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;

    apply_settings(1'b0, STALE_RESET);
    hold_requests++;
    random_events(400);
    drain_results();

    apply_settings(1'($urandom_range(1, 0)), TMO_W'($urandom_range(65535, 0)));
    random_events(350);
    drain_results();

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
